### hdl/swipe_gesture_classifier_top_macros.svh
// assertion helpers for the swipe gesture classifier
`ifndef SWIPE_GESTURE_CLASSIFIER_TOP_MACROS_SVH
`define SWIPE_GESTURE_CLASSIFIER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define SGC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SGC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sgc_pkg.sv
package sgc_pkg;

    // coordinate, timestamp and register widths
    localparam int COORD_W   = 12;
    localparam int TIME_W    = 32;
    localparam int TIMEOUT_W = 16;
    localparam int SPAN_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int NUM_DIRS  = 8;
    localparam int DIR_IDX_W = 3;

    // register reset values
    localparam logic [TIMEOUT_W-1:0] GAP_TIMEOUT_RST = 16'd800;
    localparam logic [SPAN_W-1:0]    MIN_GESTURE_RST = 13'd30;
    localparam logic [SPAN_W-1:0]    MIN_STEP_RST    = 13'd3;

    // default saturation limit for the point and direction counters
    localparam int MAX_POINTS_DEF = 1023;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GESTURE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP    = 2'd2;

    // direction codes as reported on the gesture port
    typedef enum logic [3:0] {
        DIR_NONE       = 4'd0,
        DIR_RIGHT      = 4'd1,
        DIR_LEFT       = 4'd2,
        DIR_UP         = 4'd3,
        DIR_DOWN       = 4'd4,
        DIR_DOWN_LEFT  = 4'd5,
        DIR_DOWN_RIGHT = 4'd6,
        DIR_UP_LEFT    = 4'd7,
        DIR_UP_RIGHT   = 4'd8
    } dir_t;

    // direction of the move from (sx,sy) to (ex,ey), none if the span is too short
    // the thirds are compared as a < b/3  <=>  b > 3a + 2
    function automatic dir_t direction_of(
        input logic [COORD_W-1:0] sx,
        input logic [COORD_W-1:0] sy,
        input logic [COORD_W-1:0] ex,
        input logic [COORD_W-1:0] ey,
        input logic [SPAN_W-1:0]  limit
    );
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [SPAN_W-1:0]  span;
        logic [COORD_W+1:0] ax3p;
        logic [COORD_W+1:0] ay3p;
        logic               xneg;
        logic               xpos;
        logic               ypos;
        dir_t               d;
        xneg = ex < sx;
        xpos = ex > sx;
        ypos = ey > sy;
        ax   = xneg ? (sx - ex) : (ex - sx);
        ay   = (ey < sy) ? (sy - ey) : (ey - sy);
        span = {1'b0, ax} + {1'b0, ay};
        ax3p = {2'b00, ax} + {1'b0, ax, 1'b0} + (COORD_W+2)'(2);
        ay3p = {2'b00, ay} + {1'b0, ay, 1'b0} + (COORD_W+2)'(2);
        priority if (span <= limit)
            d = DIR_NONE;
        else if ({2'b00, ax} > ay3p)
            d = xpos ? DIR_RIGHT : DIR_LEFT;
        else if ({2'b00, ay} > ax3p)
            d = ypos ? DIR_DOWN : DIR_UP;
        else if (xneg)
            d = ypos ? DIR_DOWN_LEFT : DIR_UP_LEFT;
        else
            d = ypos ? DIR_DOWN_RIGHT : DIR_UP_RIGHT;
        return d;
    endfunction

endpackage

### hdl/swipe_gesture_classifier_top.sv
// Swipe gesture classifier. Each touch point (touch_x, touch_y, time_ms) gives exactly one
// gesture code: 0 while no swipe is recognized, else 1..8 for right, left, up, down,
// down-left, down-right, up-left, up-right. A gap above gap_timeout_ms drops the gesture in
// progress; once the span from the first to the latest point exceeds min_gesture_span the
// overall direction is reported if more than a third of the points stepped that way, and the
// gesture restarts either way. The block takes one point per clock unless the output stalls:
// a point is held in the input register, the gesture state is updated as it moves on, and
// its code is registered in the result register; a stalled output holds one point in each
// of the two registers. Registers are written through cfg_write/cfg_index/cfg_data; index 3
// is ignored. The user must write only while no point is in flight; the block does not check.
`include "swipe_gesture_classifier_top_macros.svh"

module swipe_gesture_classifier_top #(
    parameter int MAX_POINTS = sgc_pkg::MAX_POINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [sgc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sgc_pkg::CFG_DAT_W-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sgc_pkg::COORD_W-1:0]         touch_x,
    input  logic [sgc_pkg::COORD_W-1:0]         touch_y,
    input  logic [sgc_pkg::TIME_W-1:0]          time_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [3:0]                          gesture
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    // configuration registers
    logic [sgc_pkg::TIMEOUT_W-1:0] gap_timeout_reg;
    logic [sgc_pkg::SPAN_W-1:0]    min_gesture_reg;
    logic [sgc_pkg::SPAN_W-1:0]    min_step_reg;

    // input register
    logic                          in_vld_reg;
    logic [sgc_pkg::COORD_W-1:0]   x_reg;
    logic [sgc_pkg::COORD_W-1:0]   y_reg;
    logic [sgc_pkg::TIME_W-1:0]    t_reg;

    // gesture state
    logic [sgc_pkg::TIME_W-1:0]    last_time_reg;
    logic [CNT_W-1:0]              point_count_reg;
    logic [sgc_pkg::COORD_W-1:0]   first_x_reg;
    logic [sgc_pkg::COORD_W-1:0]   first_y_reg;
    logic [sgc_pkg::COORD_W-1:0]   prev_x_reg;
    logic [sgc_pkg::COORD_W-1:0]   prev_y_reg;
    logic [CNT_W-1:0]              dir_count_reg [sgc_pkg::NUM_DIRS];

    // result register
    logic                          res_vld_reg;
    sgc_pkg::dir_t                 gesture_reg;

    // next values
    logic [CNT_W-1:0]              point_count_next;
    logic [sgc_pkg::COORD_W-1:0]   first_x_next;
    logic [sgc_pkg::COORD_W-1:0]   first_y_next;
    logic [CNT_W-1:0]              dir_count_next [sgc_pkg::NUM_DIRS];
    sgc_pkg::dir_t                 gesture_next;

    logic                          advance;
    logic                          in_take;
    logic                          do_step;
    logic [sgc_pkg::TIME_W-1:0]    gap;
    logic                          timed_out;
    logic [CNT_W-1:0]              pc_eff;
    logic                          is_first;
    logic [CNT_W-1:0]              pc_upd;
    sgc_pkg::dir_t                 step_dir;
    sgc_pkg::dir_t                 span_dir;
    logic [3:0]                    step_dm1;
    logic [3:0]                    span_dm1;
    logic [CNT_W-1:0]              cnt_upd [sgc_pkg::NUM_DIRS];
    logic [CNT_W-1:0]              sel_cnt;
    logic [CNT_W+1:0]              sel_cnt3;
    logic                          fire;

    // handshake: the input register moves whenever the result register can take its output
    assign advance   = !res_vld_reg || out_ready;
    assign in_ready  = !in_vld_reg || advance;
    assign in_take   = in_valid && in_ready;
    assign do_step   = in_vld_reg && advance;
    assign out_valid = res_vld_reg;
    assign gesture   = gesture_reg;

    // timeout check, gap taken modulo 2^32
    assign gap       = t_reg - last_time_reg;
    assign timed_out = gap > {{(sgc_pkg::TIME_W - sgc_pkg::TIMEOUT_W){1'b0}}, gap_timeout_reg};
    assign pc_eff    = timed_out ? '0 : point_count_reg;
    assign is_first  = (pc_eff == '0);
    assign pc_upd    = (pc_eff < CNT_MAX) ? (pc_eff + CNT_W'(1)) : pc_eff;

    // step direction from the previous point
    assign step_dir = sgc_pkg::direction_of(prev_x_reg, prev_y_reg, x_reg, y_reg, min_step_reg);
    assign step_dm1 = step_dir - 4'd1;

    // first point of the gesture, new point if the gesture is empty
    assign first_x_next = is_first ? x_reg : first_x_reg;
    assign first_y_next = is_first ? y_reg : first_y_reg;

    // per-direction step counters, cleared on timeout and saturating
    always_comb
    begin
        for (int i = 0; i < sgc_pkg::NUM_DIRS; i++)
        begin
            cnt_upd[i] = timed_out ? '0 : dir_count_reg[i];
            if (!is_first && step_dir != sgc_pkg::DIR_NONE
                && step_dm1[sgc_pkg::DIR_IDX_W-1:0] == sgc_pkg::DIR_IDX_W'(i)
                && cnt_upd[i] < CNT_MAX)
            begin
                cnt_upd[i] = cnt_upd[i] + CNT_W'(1);
            end
        end
    end

    // overall direction and the one-third vote: cnt > pc/3  <=>  3*cnt > pc
    assign span_dir = sgc_pkg::direction_of(first_x_next, first_y_next, x_reg, y_reg,
                                            min_gesture_reg);
    assign span_dm1 = span_dir - 4'd1;
    assign sel_cnt  = cnt_upd[span_dm1[sgc_pkg::DIR_IDX_W-1:0]];
    assign sel_cnt3 = {2'b00, sel_cnt} + {1'b0, sel_cnt, 1'b0};
    assign fire     = (pc_upd >= CNT_W'(2)) && (span_dir != sgc_pkg::DIR_NONE);

    always_comb
    begin
        gesture_next     = sgc_pkg::DIR_NONE;
        point_count_next = pc_upd;
        for (int i = 0; i < sgc_pkg::NUM_DIRS; i++)
        begin
            dir_count_next[i] = cnt_upd[i];
        end
        if (fire)
        begin
            if (sel_cnt3 > {2'b00, pc_upd})
            begin
                gesture_next = span_dir;
            end
            point_count_next = '0;
            for (int i = 0; i < sgc_pkg::NUM_DIRS; i++)
            begin
                dir_count_next[i] = '0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_timeout_reg <= sgc_pkg::GAP_TIMEOUT_RST;
            min_gesture_reg <= sgc_pkg::MIN_GESTURE_RST;
            min_step_reg    <= sgc_pkg::MIN_STEP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sgc_pkg::REG_GAP_TIMEOUT: gap_timeout_reg <= cfg_data;
                sgc_pkg::REG_MIN_GESTURE: min_gesture_reg <= cfg_data[sgc_pkg::SPAN_W-1:0];
                sgc_pkg::REG_MIN_STEP:    min_step_reg    <= cfg_data[sgc_pkg::SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;
            if (advance)
                res_vld_reg <= in_vld_reg;
        end
    end

    // input and result payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            x_reg <= touch_x;
            y_reg <= touch_y;
            t_reg <= time_ms;
        end
        if (do_step)
            gesture_reg <= gesture_next;
    end

    // gesture state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg   <= '0;
            point_count_reg <= '0;
            first_x_reg     <= '0;
            first_y_reg     <= '0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            for (int i = 0; i < sgc_pkg::NUM_DIRS; i++)
            begin
                dir_count_reg[i] <= '0;
            end
        end
        else if (do_step)
        begin
            last_time_reg   <= t_reg;
            point_count_reg <= point_count_next;
            first_x_reg     <= first_x_next;
            first_y_reg     <= first_y_next;
            prev_x_reg      <= x_reg;
            prev_y_reg      <= y_reg;
            for (int i = 0; i < sgc_pkg::NUM_DIRS; i++)
            begin
                dir_count_reg[i] <= dir_count_next[i];
            end
        end
    end

    // checks
    `SGC_ASSERT_NOW(a_count_bound, 1'b1, point_count_reg <= CNT_MAX, "point count over limit")
    `SGC_ASSERT_NOW(a_stall_full, !in_ready, in_vld_reg && res_vld_reg, "stall with room left")
    `SGC_ASSERT_NEXT(a_report_clears, do_step && gesture_next != sgc_pkg::DIR_NONE,
        point_count_reg == '0 && gesture_reg == $past(gesture_next), "report did not clear")
    `SGC_ASSERT_NEXT(a_step_to_result, do_step, res_vld_reg, "stepped transaction lost")

endmodule

### dv/tb_swipe_gesture_classifier_top.sv
`default_nettype none

module tb_swipe_gesture_classifier_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sgc_pkg::*;

    localparam int unsigned SAT_LIMIT   = MAX_POINTS_DEF;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned STALL_LIMIT = 3000;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [TIME_W-1:0]  t;
    } touch_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [COORD_W-1:0]   touch_x = '0;
    logic [COORD_W-1:0]   touch_y = '0;
    logic [TIME_W-1:0]    time_ms = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [3:0]           gesture;

    swipe_gesture_classifier_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .touch_x   (touch_x),
        .touch_y   (touch_y),
        .time_ms   (time_ms),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .gesture   (gesture)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // points waiting to be offered and gestures waiting to come out
    touch_t            points_pending[$];
    dir_t              expected_gestures[$];
    logic [TIME_W-1:0] stamp = '0;
    int unsigned       faults = 0;

    // classifier state as the block should hold it
    logic [TIMEOUT_W-1:0] gap_limit_ms = GAP_TIMEOUT_RST;
    logic [SPAN_W-1:0]    gesture_span_min = MIN_GESTURE_RST;
    logic [SPAN_W-1:0]    step_span_min = MIN_STEP_RST;
    logic [TIME_W-1:0]    prior_ms = '0;
    int unsigned          points_seen = 0;
    logic [COORD_W-1:0]   origin_x = '0;
    logic [COORD_W-1:0]   origin_y = '0;
    logic [COORD_W-1:0]   recent_x = '0;
    logic [COORD_W-1:0]   recent_y = '0;
    int unsigned          step_tally [NUM_DIRS] = '{default: 0};

    // compass heading of a move, none when the Manhattan span is within the limit
    function automatic dir_t heading(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                                     logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey,
                                     logic [SPAN_W-1:0] limit);
        int unsigned ax;
        int unsigned ay;
        ax = (ex >= sx) ? ex - sx : sx - ex;
        ay = (ey >= sy) ? ey - sy : sy - ey;
        if (ax + ay <= limit)
            return DIR_NONE;
        if (ay < ax / 3)
            return (ex > sx) ? DIR_RIGHT : DIR_LEFT;
        if (ay / 3 > ax)
            return (ey > sy) ? DIR_DOWN : DIR_UP;
        if (ex < sx)
            return (ey > sy) ? DIR_DOWN_LEFT : DIR_UP_LEFT;
        return (ey > sy) ? DIR_DOWN_RIGHT : DIR_UP_RIGHT;
    endfunction

    function automatic void restart_gesture();
        points_seen = 0;
        foreach (step_tally[i])
            step_tally[i] = 0;
    endfunction

    // fold one accepted point into the gesture and queue the code it yields
    function automatic void classify_point(touch_t p);
        dir_t step_dir;
        dir_t swipe_dir;
        dir_t verdict;
        verdict = DIR_NONE;
        if (p.t - prior_ms > {16'd0, gap_limit_ms})
            restart_gesture();
        if (points_seen == 0)
        begin
            origin_x = p.x;
            origin_y = p.y;
        end
        else
        begin
            step_dir = heading(recent_x, recent_y, p.x, p.y, step_span_min);
            if (step_dir != DIR_NONE && step_tally[step_dir - 1] < SAT_LIMIT)
                step_tally[step_dir - 1]++;
        end
        if (points_seen < SAT_LIMIT)
            points_seen++;
        recent_x = p.x;
        recent_y = p.y;
        prior_ms = p.t;
        if (points_seen >= 2)
        begin
            swipe_dir = heading(origin_x, origin_y, p.x, p.y, gesture_span_min);
            if (swipe_dir != DIR_NONE)
            begin
                if (step_tally[swipe_dir - 1] > points_seen / 3)
                    verdict = swipe_dir;
                restart_gesture();
            end
        end
        expected_gestures.push_back(verdict);
    endfunction

    function automatic int fit(int v);
        return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
    endfunction

    function automatic void push_point(int x, int y);
        touch_t p;
        p.x = x[COORD_W-1:0];
        p.y = y[COORD_W-1:0];
        p.t = stamp;
        points_pending.push_back(p);
    endfunction

    // mostly swipes with jitter, some stray points with arbitrary timestamps
    task automatic queue_mix(int unsigned n, int reach);
        int unsigned made;
        int          len;
        int          sx;
        int          sy;
        int          vx;
        int          vy;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                if ($urandom_range(0, 1) == 1)
                    stamp = $urandom;
                else
                    stamp += $urandom_range(0, 60);
                push_point($urandom_range(0, 4095), $urandom_range(0, 4095));
                made++;
            end
            else
            begin
                len = $urandom_range(2, 10);
                sx = $urandom_range(0, 4095);
                sy = $urandom_range(0, 4095);
                vx = int'($urandom_range(0, 2 * reach)) - reach;
                vy = int'($urandom_range(0, 2 * reach)) - reach;
                if ($urandom_range(0, 3) == 0)
                    vy = int'($urandom_range(0, 2)) - 1;
                else if ($urandom_range(0, 3) == 0)
                    vx = int'($urandom_range(0, 2)) - 1;
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        stamp += $urandom_range(0, 2000);
                    else
                        stamp += $urandom_range(0, 40);
                    push_point(fit(sx + vx * k + int'($urandom_range(0, 6)) - 3),
                               fit(sy + vy * k + int'($urandom_range(0, 6)) - 3));
                end
                made += len;
            end
        end
    endtask

    // register write, mirrored into the expected configuration
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_GAP_TIMEOUT: gap_limit_ms = data;
            REG_MIN_GESTURE: gesture_span_min = data[SPAN_W-1:0];
            REG_MIN_STEP:    step_span_min = data[SPAN_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // wait until every point is in and every gesture is out
    task automatic drain();
        do
            @(negedge clk);
        while (points_pending.size() != 0 || in_valid || expected_gestures.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    // sender: bursts of transactions with random gaps
    touch_t      offered;
    logic        offering = 1'b0;
    int unsigned gap_left = 0;
    int unsigned burst_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                classify_point(offered);
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (points_pending.size() > 0)
                begin
                    offered = points_pending.pop_front();
                    touch_x  <= offered.x;
                    touch_y  <= offered.y;
                    time_ms  <= offered.t;
                    in_valid <= 1'b1;
                    offering = 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each gesture, then pick the next ready
    dir_t        want;
    int unsigned hold_asks = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    int unsigned tick = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_gestures.size() == 0)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("gesture %0d with no point waiting for one", gesture);
                end
                else
                begin
                    want = expected_gestures.pop_front();
                    if (gesture !== want)
                    begin
                        faults++;
                        if (faults <= 10)
                            $display("gesture mismatch: expected %0d, got %0d", want, gesture);
                    end
                end
            end
            // long hold-off on request, otherwise a changing stall pattern
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(8, 90);
                end
                else
                begin
                    mode_left--;
                end
                tick++;
                case (stall_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 1) == 1);
                    default: out_ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_swipe_gesture_classifier_top: errors");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial
    begin
        int              row;
        int              reach;
        logic [15:0]     gap;
        logic [15:0]     gspan;
        logic [15:0]     sspan;
        int              dir_dx [8];
        int              dir_dy [8];
        dir_dx = '{60, -60, 0, 0, -40, 40, -40, 40};
        dir_dy = '{0, 0, -60, 60, 40, 40, -40, -40};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // first point is timed against zero and joins the first swipe below
        stamp = 100;
        push_point(2000, 2000);
        // one clean two-point swipe per direction, the rightward one led by the point above
        for (int d = 0; d < 8; d++)
        begin
            stamp += 10;
            push_point(2000, 2000);
            stamp += 10;
            push_point(2000 + dir_dx[d], 2000 + dir_dy[d]);
        end
        // corner to corner moves
        stamp += 10;
        push_point(0, 0);
        stamp += 10;
        push_point(4095, 4095);
        stamp += 10;
        push_point(4095, 0);
        stamp += 10;
        push_point(0, 4095);
        // short step, then a gap past the timeout
        stamp += 10;
        push_point(500, 500);
        stamp += 10;
        push_point(502, 501);
        stamp += 5000;
        push_point(560, 500);
        // timestamp wrapping through zero
        stamp = 32'hFFFF_FFF0;
        push_point(100, 100);
        stamp = 32'h0000_0005;
        push_point(160, 100);
        drain();

        // reset settings while the receiver holds off for a long stretch
        hold_asks++;
        queue_mix(100, 60);
        drain();

        // one long rightward drag that saturates the point and step counters
        write_reg(REG_GAP_TIMEOUT, 16'hFFFF);
        write_reg(REG_MIN_GESTURE, 16'h1FFF);
        write_reg(REG_MIN_STEP, 16'h0000);
        row = $urandom_range(0, 4095);
        // long pause first so the drag starts a fresh gesture
        stamp += 32'd100000;
        for (int k = 0; k < 1040; k++)
        begin
            stamp += 1;
            push_point(3 * k, row);
        end
        drain();
        // lowering the span lets the saturated gesture report
        write_reg(REG_MIN_GESTURE, 16'd10);
        stamp += 1;
        push_point(3200, row);
        queue_mix(60, 60);
        drain();

        // a spread of settings, extremes included
        for (int ph = 0; ph < 6; ph++)
        begin
            reach = 60;
            case (ph)
                0:
                begin
                    gap = 16'd0;
                    gspan = 16'd0;
                    sspan = 16'd0;
                end
                1:
                begin
                    gap = 16'hFFFF;
                    gspan = 16'd0;
                    sspan = 16'd8191;
                end
                2:
                begin
                    gap = 16'd20;
                    gspan = 16'd100;
                    sspan = 16'd10;
                end
                3:
                begin
                    gap = $urandom_range(0, 65535);
                    gspan = $urandom_range(0, 600);
                    sspan = $urandom_range(0, 20);
                end
                4:
                begin
                    gap = 16'd800;
                    gspan = 16'd2000;
                    sspan = 16'd3;
                    reach = 400;
                end
                default:
                begin
                    gap = GAP_TIMEOUT_RST;
                    gspan = MIN_GESTURE_RST;
                    sspan = MIN_STEP_RST;
                end
            endcase
            write_reg(REG_GAP_TIMEOUT, gap);
            write_reg(REG_MIN_GESTURE, {3'($urandom), gspan[SPAN_W-1:0]});
            write_reg(REG_MIN_STEP, {3'($urandom), sspan[SPAN_W-1:0]});
            write_reg(REG_UNUSED, 16'($urandom));
            queue_mix(60, reach);
            drain();
        end

        repeat (8) @(negedge clk);
        if (expected_gestures.size() != 0)
        begin
            faults += expected_gestures.size();
            $display("%0d gestures never came out", expected_gestures.size());
        end
        if (faults == 0)
            $display("tb_swipe_gesture_classifier_top: clean");
        else
            $display("tb_swipe_gesture_classifier_top: errors");
        $finish;
    end

endmodule

`default_nettype wire
